### sv/nhp_pkg.sv
package nhp_pkg;

    // Header geometry
    localparam int HEADER_BYTES = 48;
    localparam int OFFSET_W     = 6;
    localparam int TDATA_W      = 184;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_MODE    = 3'd3;
    localparam logic [2:0] ST_STRATUM = 3'd4;
    localparam logic [2:0] ST_POLL    = 3'd5;

    // Kiss-o'-death codes
    localparam logic [2:0] KISS_NONE = 3'd0;
    localparam logic [2:0] KISS_INIT = 3'd1;
    localparam logic [2:0] KISS_STEP = 3'd2;
    localparam logic [2:0] KISS_DENY = 3'd3;
    localparam logic [2:0] KISS_RATE = 3'd4;

    localparam logic [31:0] KISS_INIT_ID = 32'h494E4954;
    localparam logic [31:0] KISS_STEP_ID = 32'h53544550;
    localparam logic [31:0] KISS_DENY_ID = 32'h44454E59;
    localparam logic [31:0] KISS_RATE_ID = 32'h52415445;

    // Header limits
    localparam logic [2:0] HDR_VERSION = 3'd4;
    localparam logic [2:0] MODE_CLIENT = 3'd3;
    localparam logic [2:0] MODE_SERVER = 3'd4;
    localparam logic [7:0] MAX_STRATUM = 8'd16;
    localparam logic [7:0] MAX_POLL    = 8'd17;

    // Timestamp kinds
    localparam logic [1:0] KIND_REFERENCE = 2'd0;
    localparam logic [1:0] KIND_TRANSMIT  = 2'd3;

    // One classified packet, handed from the front to the back
    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       leap;
        logic [2:0]       assoc_mode;
        logic [4:0]       stratum;
        logic [4:0]       poll;
        logic [31:0]      root_delay;
        logic [31:0]      root_dispersion;
        logic [31:0]      reference_id;
        logic [2:0]       kiss_code;
        logic [3:0][63:0] stamps;
    } hdr_entry_t;

endpackage

### sv/nhp_front.sv
module nhp_front
    import nhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] payload_byte,
    input  logic       end_of_packet,
    output logic       push,
    output hdr_entry_t entry
);

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          stratum_reg, stratum_next;
    logic [7:0]          poll_reg, poll_next;
    logic [31:0]         delay_reg, delay_next;
    logic [31:0]         disp_reg, disp_next;
    logic [31:0]         refid_reg, refid_next;
    logic [3:0][63:0]    stamp_reg, stamp_next;

    logic [OFFSET_W-1:0] rel;
    logic [1:0]          slot;
    logic [2:0]          bsel;
    logic                in_header;
    logic [OFFSET_W-1:0] count_after;
    logic [2:0]          version;
    logic [2:0]          mode;
    logic [2:0]          status;
    logic [2:0]          kiss;

    assign rel       = offset_reg - OFFSET_W'(16);
    assign slot      = rel[4:3];
    assign bsel      = rel[2:0];
    assign in_header = offset_reg < OFFSET_W'(HEADER_BYTES);

    // Capture the current word into its header field
    always_comb
    begin
        first_next   = first_reg;
        stratum_next = stratum_reg;
        poll_next    = poll_reg;
        delay_next   = delay_reg;
        disp_next    = disp_reg;
        refid_next   = refid_reg;
        stamp_next   = stamp_reg;
        if (accept && in_header)
        begin
            if (offset_reg == OFFSET_W'(0))
                first_next = payload_byte;
            else if (offset_reg == OFFSET_W'(1))
                stratum_next = payload_byte;
            else if (offset_reg == OFFSET_W'(2))
                poll_next = payload_byte;
            else if (offset_reg >= OFFSET_W'(4) && offset_reg < OFFSET_W'(8))
                delay_next[{2'd3 - offset_reg[1:0], 3'b000} +: 8] = payload_byte;
            else if (offset_reg >= OFFSET_W'(8) && offset_reg < OFFSET_W'(12))
                disp_next[{2'd3 - offset_reg[1:0], 3'b000} +: 8] = payload_byte;
            else if (offset_reg >= OFFSET_W'(12) && offset_reg < OFFSET_W'(16))
                refid_next[{2'd3 - offset_reg[1:0], 3'b000} +: 8] = payload_byte;
            else if (offset_reg >= OFFSET_W'(16))
                stamp_next[slot][{3'd7 - bsel, 3'b000} +: 8] = payload_byte;
        end
    end

    // Advance the byte count, saturating at the header length
    assign count_after = in_header ? offset_reg + OFFSET_W'(1) : offset_reg;

    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
            offset_next = end_of_packet ? '0 : count_after;
    end

    // Classify the packet on its last word
    assign version = first_next[5:3];
    assign mode    = first_next[2:0];

    always_comb
    begin
        if (count_after < OFFSET_W'(HEADER_BYTES))
            status = ST_SHORT;
        else if (version != HDR_VERSION)
            status = ST_VERSION;
        else if (mode != MODE_CLIENT && mode != MODE_SERVER)
            status = ST_MODE;
        else if (stratum_next > MAX_STRATUM)
            status = ST_STRATUM;
        else if (poll_next > MAX_POLL)
            status = ST_POLL;
        else
            status = ST_OK;
    end

    always_comb
    begin
        kiss = KISS_NONE;
        if (stratum_next == 8'd0)
        begin
            if (refid_next == KISS_INIT_ID)
                kiss = KISS_INIT;
            else if (refid_next == KISS_STEP_ID)
                kiss = KISS_STEP;
            else if (refid_next == KISS_DENY_ID)
                kiss = KISS_DENY;
            else if (refid_next == KISS_RATE_ID)
                kiss = KISS_RATE;
        end
    end

    assign push                  = accept && end_of_packet;
    assign entry.status          = status;
    assign entry.leap            = first_next[7:6];
    assign entry.assoc_mode      = mode;
    assign entry.stratum         = stratum_next[4:0];
    assign entry.poll            = poll_next[4:0];
    assign entry.root_delay      = delay_next;
    assign entry.root_dispersion = disp_next;
    assign entry.reference_id    = refid_next;
    assign entry.kiss_code       = kiss;
    assign entry.stamps          = stamp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

    // Header fields, overwritten by the header bytes each packet carries
    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        stratum_reg <= stratum_next;
        poll_reg    <= poll_next;
        delay_reg   <= delay_next;
        disp_reg    <= disp_next;
        refid_reg   <= refid_next;
        stamp_reg   <= stamp_next;
    end

    a_offset_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFFSET_W'(HEADER_BYTES))
        else $error("byte count ran past the header length");

    a_offset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> offset_reg == '0)
        else $error("byte count not cleared after last word");

endmodule

### sv/nhp_queue.sv
module nhp_queue
    import nhp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hdr_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output hdr_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hdr_entry_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("packet queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("packet queue underflow");

endmodule

### sv/nhp_back.sv
module nhp_back
    import nhp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  hdr_entry_t         head_entry,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic [1:0]         kind_reg, kind_next;
    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [1:0]         user_reg, user_next;
    logic               last_reg, last_next;
    logic               load;
    logic               is_error;

    assign is_error = head_entry.status != ST_OK;
    assign load     = head_valid && (!valid_reg || m_tready);
    assign pop      = load && (is_error || kind_reg == KIND_TRANSMIT);

    // Build the next result word from the queue head
    always_comb
    begin
        kind_next  = kind_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            kind_next  = pop ? KIND_REFERENCE : kind_reg + 2'd1;
            if (is_error)
            begin
                data_next = {{(TDATA_W - 8){1'b0}},
                             head_entry.assoc_mode, head_entry.leap, head_entry.status};
                user_next = KIND_REFERENCE;
                last_next = 1'b1;
            end
            else
            begin
                data_next = {3'b000,
                             head_entry.stamps[kind_reg],
                             head_entry.kiss_code,
                             head_entry.reference_id,
                             head_entry.root_dispersion,
                             head_entry.root_delay,
                             head_entry.poll,
                             head_entry.stratum,
                             head_entry.assoc_mode,
                             head_entry.leap,
                             head_entry.status};
                user_next = kind_reg;
                last_next = kind_reg == KIND_TRANSMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_REFERENCE;
            valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg  <= kind_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg[2:0] != ST_OK |-> last_reg)
        else $error("error word not marked last");

    a_last_on_transmit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg[2:0] == ST_OK |-> last_reg == (user_reg == KIND_TRANSMIT))
        else $error("last mark not on transmit timestamp");

    a_expansion_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg != KIND_REFERENCE |-> head_valid)
        else $error("queue head lost during timestamp expansion");

endmodule

### sv/ntp_header_parser.sv
// Channel  Dir  Ports                            Word contents (lowest bit up)
// -------  ---  -------------------------------  ------------------------------------------
// s_*      in   s_tvalid s_tready s_tdata s_tlast payload_byte; tlast = end_of_packet
// m_*      out  m_tvalid m_tready m_tdata        status leap assoc_mode stratum_out poll_out
//               m_tuser m_tlast                  root_delay root_dispersion reference_id
//                                                kiss_code stamp_value; tuser = stamp_kind;
//                                                tlast = last_result
//
// One payload word is accepted per cycle while the queue is not full; the front captures header
// fields and classifies the packet on its last word. Each packet leaves one result word on
// error or four (one per timestamp) on success, one per cycle from the back while m_tready is high.
// The packet's entry is written into the queue, and the back then registers its first result word.
// A QUEUE_DEPTH-entry packet queue decouples the two; s_tready drops only when it
// is full. Reset is asynchronous and active low; it clears the counters and flags.
module ntp_header_parser
    import nhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // payload_byte[7:0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // status, leap, assoc_mode, stratum_out,
                                          // poll_out, root_delay, root_dispersion,
                                          // reference_id, kiss_code, stamp_value, pad
    output logic [1:0]         m_tuser,   // stamp_kind[1:0]
    output logic               m_tlast
);

    logic       accept;
    logic       push;
    logic       pop;
    logic       full;
    logic       head_valid;
    hdr_entry_t push_entry;
    hdr_entry_t head_entry;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    nhp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .payload_byte  (s_tdata),
        .end_of_packet (s_tlast),
        .push          (push),
        .entry         (push_entry)
    );

    nhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    nhp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### dv/testbench.sv
module testbench;
    import nhp_pkg::*;

    // One expected result word, field by field
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  leap;
        logic [2:0]  assoc_mode;
        logic [4:0]  stratum;
        logic [4:0]  poll;
        logic [31:0] root_delay;
        logic [31:0] root_dispersion;
        logic [31:0] reference_id;
        logic [2:0]  kiss_code;
        logic [1:0]  stamp_kind;
        logic [63:0] stamp_value;
        logic        last_result;
    } ntp_result_t;

    // Header capture shadow and the queue of header results it predicts
    class ntp_scoreboard;
        logic [5:0]  offset = '0;
        logic [7:0]  byte0 = '0;
        logic [7:0]  stratum = '0;
        logic [7:0]  poll = '0;
        logic [31:0] delay = '0;
        logic [31:0] dispersion = '0;
        logic [31:0] refid = '0;
        logic [63:0] stamps [4] = '{default: '0};
        ntp_result_t expected_results[$];
        int          fails = 0;

        function int pending();
            return expected_results.size();
        endfunction

        function logic [2:0] kiss_lookup();
            if (stratum != 8'd0)
                return KISS_NONE;
            case (refid)
                KISS_INIT_ID: return KISS_INIT;
                KISS_STEP_ID: return KISS_STEP;
                KISS_DENY_ID: return KISS_DENY;
                KISS_RATE_ID: return KISS_RATE;
                default:      return KISS_NONE;
            endcase
        endfunction

        // Capture one payload word; classify the packet on its last word
        function void note_byte(logic [7:0] b, logic last);
            int          idx;
            int          rel;
            logic [2:0]  version;
            logic [2:0]  mode;
            logic [2:0]  status;
            ntp_result_t r;

            idx = offset;
            if (idx < HEADER_BYTES)
            begin
                if (idx == 0)
                    byte0 = b;
                else if (idx == 1)
                    stratum = b;
                else if (idx == 2)
                    poll = b;
                else if (idx >= 4 && idx < 8)
                    delay[(7 - idx) * 8 +: 8] = b;
                else if (idx >= 8 && idx < 12)
                    dispersion[(11 - idx) * 8 +: 8] = b;
                else if (idx >= 12 && idx < 16)
                    refid[(15 - idx) * 8 +: 8] = b;
                else if (idx >= 16)
                begin
                    rel = idx - 16;
                    stamps[rel / 8][(7 - rel % 8) * 8 +: 8] = b;
                end
                offset = offset + 6'd1;
            end
            if (!last)
                return;

            version = byte0[5:3];
            mode    = byte0[2:0];
            if (offset < HEADER_BYTES)
                status = ST_SHORT;
            else if (version != HDR_VERSION)
                status = ST_VERSION;
            else if (mode != MODE_CLIENT && mode != MODE_SERVER)
                status = ST_MODE;
            else if (stratum > MAX_STRATUM)
                status = ST_STRATUM;
            else if (poll > MAX_POLL)
                status = ST_POLL;
            else
                status = ST_OK;
            offset = '0;

            r = '0;
            r.status     = status;
            r.leap       = byte0[7:6];
            r.assoc_mode = mode;
            if (status != ST_OK)
            begin
                r.last_result = 1'b1;
                expected_results.push_back(r);
                return;
            end
            r.stratum         = stratum[4:0];
            r.poll            = poll[4:0];
            r.root_delay      = delay;
            r.root_dispersion = dispersion;
            r.reference_id    = refid;
            r.kiss_code       = kiss_lookup();
            for (int k = 0; k < 4; k++)
            begin
                r.stamp_kind  = k[1:0];
                r.stamp_value = stamps[k];
                r.last_result = (k[1:0] == KIND_TRANSMIT);
                expected_results.push_back(r);
            end
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                fails++;
            end
        endfunction

        // Match one result word against the oldest prediction
        function void check_result(logic [TDATA_W-1:0] d, logic [1:0] kind, logic last);
            ntp_result_t e;

            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual %h", $time, d);
                fails++;
                return;
            end
            e = expected_results.pop_front();
            compare("status", e.status, d[2:0]);
            compare("leap", e.leap, d[4:3]);
            compare("assoc_mode", e.assoc_mode, d[7:5]);
            compare("stratum_out", e.stratum, d[12:8]);
            compare("poll_out", e.poll, d[17:13]);
            compare("root_delay", e.root_delay, d[49:18]);
            compare("root_dispersion", e.root_dispersion, d[81:50]);
            compare("reference_id", e.reference_id, d[113:82]);
            compare("kiss_code", e.kiss_code, d[116:114]);
            compare("stamp_value", e.stamp_value, d[180:117]);
            compare("stamp_kind", e.stamp_kind, kind);
            compare("last_result", e.last_result, last);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    ntp_scoreboard sb = new;
    logic [7:0]    pkt_bytes[$];
    int            bytes_sent = 0;
    int            src_idle = 10;
    int            sink_idle = 74;
    int            hold_requests = 0;

    ntp_header_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        static int hold_left = 0;
        static int hold_seen = 0;
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle);
    end

    // Check each result word as it is taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Offer one payload word, with random gaps ahead of it
    task push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task send_packet();
        foreach (pkt_bytes[i])
            push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    task fill_random(input int len);
        pkt_bytes.delete();
        repeat (len)
            pkt_bytes.push_back($urandom_range(255));
    endtask

    // Overwrite the first three header bytes and the reference ID; the rest stays as filled
    task set_header(input logic [7:0] b0, input logic [7:0] st, input logic [7:0] pl,
                    input logic [31:0] rid);
        pkt_bytes[0] = b0;
        pkt_bytes[1] = st;
        pkt_bytes[2] = pl;
        for (int i = 0; i < 4; i++)
            pkt_bytes[12 + i] = rid[(3 - i) * 8 +: 8];
    endtask

    task header_packet(input int len, input logic [7:0] b0, input logic [7:0] st,
                       input logic [7:0] pl, input logic [31:0] rid);
        fill_random(len);
        set_header(b0, st, pl, rid);
        send_packet();
    endtask

    // Mostly well-formed packets, some noise and some with one bad field
    task random_packet();
        int          pick;
        int          len;
        logic [7:0]  b0;
        logic [7:0]  st;
        logic [7:0]  pl;
        logic [31:0] rid;

        pick = $urandom_range(99);
        if (pick >= 80 && pick < 90)
        begin
            fill_random($urandom_range(1, 60));
            return;
        end
        len = HEADER_BYTES;
        if ($urandom_range(3) == 0)
            len = len + $urandom_range(1, 12);
        fill_random(len);
        b0 = {2'($urandom_range(3)), HDR_VERSION,
              ($urandom_range(1) != 0) ? MODE_SERVER : MODE_CLIENT};
        st = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 16));
        pl = 8'($urandom_range(17));
        case ($urandom_range(9))
            0:       rid = KISS_INIT_ID;
            1:       rid = KISS_STEP_ID;
            2:       rid = KISS_DENY_ID;
            3:       rid = KISS_RATE_ID;
            default: rid = $urandom;
        endcase
        if (pick >= 90)
        begin
            case ($urandom_range(3))
                0: b0[5:3] = HDR_VERSION + 3'($urandom_range(1, 7));
                1: b0[2:0] = ($urandom_range(1) != 0) ? 3'($urandom_range(0, 2))
                                                        : 3'($urandom_range(5, 7));
                2: st = 8'($urandom_range(17, 255));
                default: pl = 8'($urandom_range(18, 255));
            endcase
        end
        set_header(b0, st, pl, rid);
    endtask

    task random_phase(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            random_packet();
            send_packet();
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lengths, limits and a kiss code
        fill_random(1);
        pkt_bytes[0] = 8'hFF;
        send_packet();
        header_packet(47, 8'h23, 8'd1, 8'd6, 32'h0);
        header_packet(48, 8'h23, 8'd0, 8'd0, KISS_INIT_ID);
        fill_random(64);
        foreach (pkt_bytes[i])
            pkt_bytes[i] = 8'hFF;
        set_header(8'hE3, 8'd16, 8'd17, 32'hFFFF_FFFF);
        send_packet();

        // Random traffic under three idling patterns
        random_phase(40);
        src_idle  = 74;
        sink_idle = 10;
        random_phase(40);
        src_idle  = 0;
        sink_idle = 0;
        hold_requests++;
        random_phase(110);
        s_tvalid <= 1'b0;

        // Drain, then keep watching for stray words
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20 * 300000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
